/* rtl/core/cnw_pkg.sv */
// cnw_pkg: types, constants and lookup functions for the cpio newc walker
// no dependencies; used by every module in rtl/core
package cnw_pkg;

  // walker phase, one-hot
  typedef enum logic [5:0] {
    PH_HEADER     = 6'b000001,
    PH_NAME       = 6'b000010,
    PH_NAMEPAD    = 6'b000100,
    PH_CONTENT    = 6'b001000,
    PH_CONTENTPAD = 6'b010000,
    PH_STOPPED    = 6'b100000
  } phase_e;

  // region codes reported per byte
  localparam logic [2:0] REG_HEADER     = 3'd0;
  localparam logic [2:0] REG_NAME       = 3'd1;
  localparam logic [2:0] REG_NAMEPAD    = 3'd2;
  localparam logic [2:0] REG_CONTENT    = 3'd3;
  localparam logic [2:0] REG_CONTENTPAD = 3'd4;
  localparam logic [2:0] REG_STOPPED    = 3'd5;

  // status codes
  localparam logic [1:0] ST_WALKING   = 2'd0;
  localparam logic [1:0] ST_TRAILER   = 2'd1;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
  localparam logic [1:0] ST_BAD_HEX   = 2'd3;

  // header layout (byte offsets within the 110-byte header)
  localparam logic [6:0] MAGIC_LEN   = 7'd6;
  localparam logic [6:0] FSIZE_FIRST = 7'd54;
  localparam logic [6:0] FSIZE_LAST  = 7'd61;
  localparam logic [6:0] NSIZE_FIRST = 7'd94;
  localparam logic [6:0] NSIZE_LAST  = 7'd101;
  localparam logic [6:0] HDR_LAST    = 7'd109;

  localparam int TRAILER_NAME_SIZE = 11;
  localparam int TRAILER_TEXT_LEN  = 10;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_size;
    logic [15:0] index;
    logic        name_last;
    logic        name_valid;
    logic [2:0]  region;
    logic [7:0]  data;
  } result_t;

  // hex digit decode
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // "070701"
  function automatic logic [7:0] magic_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h37;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "TRAILER!!!"
  function automatic logic [7:0] trailer_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/cnw_walker.sv */
// cnw_walker: walk state registers and the per-byte classification step
// depends on cnw_pkg
module cnw_walker #(
  parameter int SIZE_BITS  = 32,
  parameter int ENTRY_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             restart_i,
  output cnw_pkg::result_t result_o
);

  cnw_pkg::phase_e       phase_q, phase_d;
  logic [6:0]            off_q, off_d;
  logic [SIZE_BITS-1:0]  acc_q, acc_d;
  logic [SIZE_BITS-1:0]  name_len_q, name_len_d;
  logic [SIZE_BITS-1:0]  cont_len_q, cont_len_d;
  logic [SIZE_BITS-1:0]  rem_q, rem_d;
  logic [1:0]            align_q, align_d;
  logic [ENTRY_BITS-1:0] count_q, count_d;
  logic                  match_q, match_d;
  logic [1:0]            status_q, status_d;

  // state as seen by this byte, after an optional restart
  cnw_pkg::phase_e       ph_c;
  logic [6:0]            off_c;
  logic [SIZE_BITS-1:0]  acc_c, name_len_c, cont_len_c, rem_c;
  logic [1:0]            align_c;
  logic [ENTRY_BITS-1:0] count_c;
  logic                  match_c;

  logic [2:0]            region;
  logic                  name_valid, name_last, trailer;
  logic                  go_after_name, go_enter_content, go_after_content, go_next_entry;
  logic [SIZE_BITS-1:0]  pos;
  cnw_pkg::hex_t         hex;

  // restart folds the reset values in front of the step
  always_comb begin
    if (restart_i) begin
      ph_c       = cnw_pkg::PH_HEADER;
      off_c      = '0;
      acc_c      = '0;
      name_len_c = '0;
      cont_len_c = '0;
      rem_c      = '0;
      align_c    = '0;
      count_c    = '0;
      match_c    = 1'b1;
    end else begin
      ph_c       = phase_q;
      off_c      = off_q;
      acc_c      = acc_q;
      name_len_c = name_len_q;
      cont_len_c = cont_len_q;
      rem_c      = rem_q;
      align_c    = align_q;
      count_c    = count_q;
      match_c    = match_q;
    end
  end

  assign hex = cnw_pkg::hex_decode(byte_i);
  assign pos = name_len_c - rem_c;

  // one classification step
  always_comb begin
    phase_d    = ph_c;
    off_d      = off_c;
    acc_d      = acc_c;
    name_len_d = name_len_c;
    cont_len_d = cont_len_c;
    rem_d      = rem_c;
    count_d    = count_c;
    match_d    = match_c;
    status_d   = restart_i ? cnw_pkg::ST_WALKING : status_q;
    align_d    = (ph_c != cnw_pkg::PH_STOPPED) ? align_c + 2'd1 : align_c;
    region     = cnw_pkg::REG_STOPPED;
    name_valid = 1'b0;
    name_last  = 1'b0;
    trailer    = 1'b0;
    go_after_name    = 1'b0;
    go_enter_content = 1'b0;
    go_after_content = 1'b0;
    go_next_entry    = 1'b0;

    unique case (ph_c)
      cnw_pkg::PH_HEADER: begin
        region = cnw_pkg::REG_HEADER;
        if (off_c < cnw_pkg::MAGIC_LEN &&
            byte_i != cnw_pkg::magic_char(off_c[2:0])) begin
          status_d = cnw_pkg::ST_BAD_MAGIC;
          phase_d  = cnw_pkg::PH_STOPPED;
          region   = cnw_pkg::REG_STOPPED;
        end else if (((off_c >= cnw_pkg::FSIZE_FIRST && off_c <= cnw_pkg::FSIZE_LAST) ||
                      (off_c >= cnw_pkg::NSIZE_FIRST && off_c <= cnw_pkg::NSIZE_LAST)) &&
                     !hex.ok) begin
          status_d = cnw_pkg::ST_BAD_HEX;
          phase_d  = cnw_pkg::PH_STOPPED;
          region   = cnw_pkg::REG_STOPPED;
        end else begin
          // size field digits shift in from the low end
          if ((off_c >= cnw_pkg::FSIZE_FIRST && off_c <= cnw_pkg::FSIZE_LAST) ||
              (off_c >= cnw_pkg::NSIZE_FIRST && off_c <= cnw_pkg::NSIZE_LAST)) begin
            acc_d = {acc_c[SIZE_BITS-5:0], hex.val};
            if (off_c == cnw_pkg::FSIZE_LAST) begin
              cont_len_d = acc_d;
              acc_d      = '0;
            end
            if (off_c == cnw_pkg::NSIZE_LAST) begin
              name_len_d = acc_d;
              acc_d      = '0;
            end
          end
          if (off_c >= cnw_pkg::HDR_LAST) begin
            rem_d = name_len_d;
            if (name_len_d == '0) begin
              go_after_name = 1'b1;
            end else begin
              phase_d = cnw_pkg::PH_NAME;
            end
          end else begin
            off_d = off_c + 7'd1;
          end
        end
      end
      cnw_pkg::PH_NAME: begin
        if (rem_c > SIZE_BITS'(1)) begin
          region     = cnw_pkg::REG_NAME;
          name_valid = (byte_i != 8'h00);
          name_last  = (rem_c == SIZE_BITS'(2));
          if (pos < SIZE_BITS'(cnw_pkg::TRAILER_TEXT_LEN)) begin
            if (byte_i != cnw_pkg::trailer_char(pos[3:0])) begin
              match_d = 1'b0;
            end
            trailer = (pos == SIZE_BITS'(cnw_pkg::TRAILER_TEXT_LEN - 1)) && match_d &&
                      (name_len_c == SIZE_BITS'(cnw_pkg::TRAILER_NAME_SIZE));
          end
        end else begin
          region = cnw_pkg::REG_NAMEPAD;
        end
        rem_d = rem_c - SIZE_BITS'(1);
        if (trailer) begin
          status_d = cnw_pkg::ST_TRAILER;
          phase_d  = cnw_pkg::PH_STOPPED;
        end else if (rem_d == '0) begin
          go_after_name = 1'b1;
        end
      end
      cnw_pkg::PH_NAMEPAD: begin
        region = cnw_pkg::REG_NAMEPAD;
        go_enter_content = (align_d == 2'd0);
      end
      cnw_pkg::PH_CONTENT: begin
        region = cnw_pkg::REG_CONTENT;
        rem_d  = rem_c - SIZE_BITS'(1);
        go_after_content = (rem_d == '0);
      end
      cnw_pkg::PH_CONTENTPAD: begin
        region = cnw_pkg::REG_CONTENTPAD;
        go_next_entry = (align_d == 2'd0);
      end
      default: begin
        region = cnw_pkg::REG_STOPPED;
      end
    endcase

    // chained transitions between phases
    if (go_after_name) begin
      if (align_d == 2'd0) begin
        go_enter_content = 1'b1;
      end else begin
        phase_d = cnw_pkg::PH_NAMEPAD;
      end
    end
    if (go_enter_content) begin
      rem_d = cont_len_d;
      if (cont_len_d == '0) begin
        go_after_content = 1'b1;
      end else begin
        phase_d = cnw_pkg::PH_CONTENT;
      end
    end
    if (go_after_content) begin
      if (align_d == 2'd0) begin
        go_next_entry = 1'b1;
      end else begin
        phase_d = cnw_pkg::PH_CONTENTPAD;
      end
    end
    if (go_next_entry) begin
      count_d    = count_c + ENTRY_BITS'(1);
      phase_d    = cnw_pkg::PH_HEADER;
      off_d      = '0;
      acc_d      = '0;
      name_len_d = '0;
      cont_len_d = '0;
      rem_d      = '0;
      match_d    = 1'b1;
    end
  end

  // result for this byte
  always_comb begin
    result_o.data       = byte_i;
    result_o.region     = region;
    result_o.name_valid = name_valid;
    result_o.name_last  = name_last;
    result_o.index      = 16'(count_c);
    result_o.entry_size = 32'(cont_len_c);
    result_o.status     = status_d;
  end

  // walk state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= cnw_pkg::PH_HEADER;
      off_q      <= '0;
      acc_q      <= '0;
      name_len_q <= '0;
      cont_len_q <= '0;
      rem_q      <= '0;
      align_q    <= '0;
      count_q    <= '0;
      match_q    <= 1'b1;
      status_q   <= cnw_pkg::ST_WALKING;
    end else if (step_i) begin
      phase_q    <= phase_d;
      off_q      <= off_d;
      acc_q      <= acc_d;
      name_len_q <= name_len_d;
      cont_len_q <= cont_len_d;
      rem_q      <= rem_d;
      align_q    <= align_d;
      count_q    <= count_d;
      match_q    <= match_d;
      status_q   <= status_d;
    end
  end

endmodule

/* rtl/core/cnw_out_reg.sv */
// cnw_out_reg: result register on the master side of the walker
// depends on cnw_pkg
module cnw_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cnw_pkg::result_t result_i,
  input  logic             ready_i,
  output logic             can_load_o,
  output logic             valid_o,
  output cnw_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  cnw_pkg::result_t res_q;

  // room when empty or when the held request leaves this cycle
  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

/* rtl/core/cpio_newc_archive_walker.sv */
// cpio_newc_archive_walker: one archive byte per request in, one tagged result out.
// Path: input register, walk step (a single pass between the two registers), result register.
// Throughput: one byte per cycle unless a low m_axis_tready fills the result register.
// Reset (rst_ni low, asynchronous) empties both registers and returns the walk to header
// byte 0 with entry count 0 and status walking; restart in tuser does the same per byte.
// Depends on cnw_pkg, cnw_walker and cnw_out_reg.
module cpio_newc_archive_walker #(
  parameter int SIZE_BITS  = 32,
  parameter int ENTRY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] out_byte, [23:8] entry_index,
                                      // [55:24] entry_file_size, [57:56] status, rest 0
  output logic [3:0]  m_axis_tuser,   // [2:0] region, [3] name_char_valid
  output logic        m_axis_tlast    // name_last
);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             in_restart_q;
  logic             step;
  logic             can_load;
  cnw_pkg::result_t step_res, out_res;

  // a held byte steps whenever the result register has room
  assign step          = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  cnw_walker #(
    .SIZE_BITS (SIZE_BITS),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .restart_i(in_restart_q),
    .result_o (step_res)
  );

  cnw_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step),
    .result_i  (step_res),
    .ready_i   (m_axis_tready),
    .can_load_o(can_load),
    .valid_o   (m_axis_tvalid),
    .result_o  (out_res)
  );

  // pack the result onto the master side
  assign m_axis_tdata = {6'd0, out_res.status, out_res.entry_size, out_res.index, out_res.data};
  assign m_axis_tuser = {out_res.name_valid, out_res.region};
  assign m_axis_tlast = out_res.name_last;

endmodule

/* test/tb_cpio_newc_archive_walker.sv */
`timescale 1ns / 1ps
// tb_cpio_newc_archive_walker: self-checking bench that streams cpio newc archives into the
// walker, predicts every tagged byte with its own walk model and checks results in order
// depends on cnw_pkg and cpio_newc_archive_walker

module tb_cpio_newc_archive_walker;
  import cnw_pkg::*;

  localparam logic [47:0] MAGIC_TEXT   = "070701";
  localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";
  localparam logic [47:0] NOT_HEX      = "/:@G`g";
  localparam int          HDR_BYTES    = int'(HDR_LAST) + 1;
  localparam int          RANDOM_UNTIL = 1250;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [7:0] out_byte, [23:8] entry_index,
                               // [55:24] entry_file_size, [57:56] status
  logic [3:0]  m_axis_tuser;   // [2:0] region, [3] name_char_valid
  logic        m_axis_tlast;   // name_last

  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int bytes_sent     = 0;
  int arch_pos       = 0;

  // value of a hex digit, -1 for anything else
  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // walk model and in-order store of predicted results
  class walk_scoreboard;
    phase_e      walk_phase;
    logic [6:0]  hdr_pos;
    logic [31:0] digit_acc;
    logic [31:0] name_size;
    logic [31:0] content_len;
    logic [31:0] left;
    logic [1:0]  align;
    logic [15:0] entry_count;
    bit          trailer_ok;
    logic [1:0]  walk_status;
    result_t     pending_results[$];
    int          mismatches;
    int          region_count[6];
    int          stop_count[4];

    function new();
      full_reset();
    endfunction

    function void clear_entry();
      walk_phase  = PH_HEADER;
      hdr_pos     = 7'd0;
      digit_acc   = '0;
      name_size   = '0;
      content_len = '0;
      left        = '0;
      trailer_ok  = 1'b1;
    endfunction

    function void full_reset();
      clear_entry();
      align       = 2'd0;
      entry_count = 16'd0;
      walk_status = ST_WALKING;
    endfunction

    function void halt(logic [1:0] code);
      walk_status = code;
      walk_phase  = PH_STOPPED;
      stop_count[code]++;
    endfunction

    function void advance_entry();
      entry_count = entry_count + 16'd1;
      clear_entry();
    endfunction

    function void content_done();
      if (align == 2'd0) advance_entry();
      else walk_phase = PH_CONTENTPAD;
    endfunction

    function void start_content();
      left = content_len;
      if (left == 32'd0) content_done();
      else walk_phase = PH_CONTENT;
    endfunction

    function void name_done();
      if (align == 2'd0) start_content();
      else walk_phase = PH_NAMEPAD;
    endfunction

    // one archive byte through the walk
    function result_t walk_byte(logic [7:0] b, logic rs);
      result_t     r;
      int          d;
      logic [31:0] pos;
      bit          trailer_hit;
      if (rs) full_reset();
      r             = '0;
      r.data        = b;
      r.region      = REG_STOPPED;
      r.index       = entry_count;
      r.entry_size  = content_len;
      trailer_hit   = 1'b0;
      if (walk_phase != PH_STOPPED) align = align + 2'd1;
      case (walk_phase)
        PH_HEADER: begin
          r.region = REG_HEADER;
          if (hdr_pos < MAGIC_LEN) begin
            if (b != MAGIC_TEXT[8*(5-int'(hdr_pos)) +: 8]) begin
              halt(ST_BAD_MAGIC);
              r.region = REG_STOPPED;
            end
          end else if ((hdr_pos >= FSIZE_FIRST && hdr_pos <= FSIZE_LAST) ||
                       (hdr_pos >= NSIZE_FIRST && hdr_pos <= NSIZE_LAST)) begin
            d = hex_digit_value(b);
            if (d < 0) begin
              halt(ST_BAD_HEX);
              r.region = REG_STOPPED;
            end else begin
              digit_acc = {digit_acc[27:0], 4'(d)};
              if (hdr_pos == FSIZE_LAST) begin
                content_len = digit_acc;
                digit_acc   = '0;
              end
              if (hdr_pos == NSIZE_LAST) begin
                name_size = digit_acc;
                digit_acc = '0;
              end
            end
          end
          // a stopping byte leaves the offset alone
          if (walk_phase == PH_HEADER) begin
            if (hdr_pos >= HDR_LAST) begin
              left = name_size;
              if (name_size == 32'd0) name_done();
              else walk_phase = PH_NAME;
            end else begin
              hdr_pos = hdr_pos + 7'd1;
            end
          end
        end
        PH_NAME: begin
          pos = name_size - left;
          if (left > 32'd1) begin
            r.region     = REG_NAME;
            r.name_valid = (b != 8'h00);
            r.name_last  = (left == 32'd2);
            if (pos < TRAILER_TEXT_LEN) begin
              if (b != TRAILER_TEXT[8*(TRAILER_TEXT_LEN-1-int'(pos)) +: 8]) trailer_ok = 1'b0;
              if (pos == TRAILER_TEXT_LEN - 1 && trailer_ok && name_size == TRAILER_NAME_SIZE)
                trailer_hit = 1'b1;
            end
          end else begin
            r.region = REG_NAMEPAD;
          end
          left = left - 32'd1;
          if (trailer_hit) halt(ST_TRAILER);
          else if (left == 32'd0) name_done();
        end
        PH_NAMEPAD: begin
          r.region = REG_NAMEPAD;
          if (align == 2'd0) start_content();
        end
        PH_CONTENT: begin
          r.region = REG_CONTENT;
          left = left - 32'd1;
          if (left == 32'd0) content_done();
        end
        PH_CONTENTPAD: begin
          r.region = REG_CONTENTPAD;
          if (align == 2'd0) advance_entry();
        end
        default: r.region = REG_STOPPED;
      endcase
      r.status = walk_status;
      region_count[r.region]++;
      return r;
    endfunction

    function void note_request(logic [7:0] b, logic rs);
      pending_results.push_back(walk_byte(b, rs));
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", fname, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request waiting, out_byte %0h", got.data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("out_byte", want.data, got.data);
      compare_field("region", want.region, got.region);
      compare_field("name_char_valid", want.name_valid, got.name_valid);
      compare_field("name_last", want.name_last, got.name_last);
      compare_field("entry_index", want.index, got.index);
      compare_field("entry_file_size", want.entry_size, got.entry_size);
      compare_field("status", want.status, got.status);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  walk_scoreboard board;

  cpio_newc_archive_walker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // byte values with the extremes favoured
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 31))
      0:       return 8'h00;
      1:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  // hex digit in either case
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // one request on the input side, with an optional gap before it
  task automatic send_byte(input logic [7:0] b, input logic rs);
    if (sender_idles && $urandom_range(0, 11) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(b, rs);
    bytes_sent++;
    arch_pos = rs ? 1 : arch_pos + 1;
    @(negedge clk_i);
  endtask

  task automatic send_noise(input int n);
    repeat (n) begin
      send_byte(any_byte(), 1'b0);
    end
  endtask

  // first nbytes of a header, one byte optionally replaced
  task automatic emit_header(input logic [31:0] fsz, input logic [31:0] nsz, input bit first,
                             input int bad_off, input logic [7:0] bad_val, input int nbytes);
    logic [7:0] b;
    int         off;
    for (off = 0; off < nbytes; off++) begin
      if (off < MAGIC_LEN) b = MAGIC_TEXT[8*(5-off) +: 8];
      else if (off >= FSIZE_FIRST && off <= FSIZE_LAST)
        b = hex_char(fsz[4*(int'(FSIZE_LAST)-off) +: 4]);
      else if (off >= NSIZE_FIRST && off <= NSIZE_LAST)
        b = hex_char(nsz[4*(int'(NSIZE_LAST)-off) +: 4]);
      else b = any_byte();
      if (off == bad_off) b = bad_val;
      send_byte(b, first && off == 0);
    end
  endtask

  // full entry; body_cap limits the bytes after the header, -1 for none
  task automatic emit_entry(input logic [31:0] fsz, input logic [31:0] nsz, input string nm,
                            input bit first, input int body_cap);
    longint     i;
    int         budget;
    logic [7:0] b;
    budget = (body_cap < 0) ? 32'h7FFF_FFFF : body_cap;
    emit_header(fsz, nsz, first, -1, 8'h00, HDR_BYTES);
    for (i = 0; i < nsz && budget > 0; i++) begin
      if (i < nm.len()) b = nm[int'(i)];
      else if (i == longint'(nsz) - 1) b = ($urandom_range(0, 7) == 0) ? name_char() : 8'h00;
      else b = name_char();
      send_byte(b, 1'b0);
      budget--;
    end
    while (arch_pos % 4 != 0 && budget > 0) begin
      send_byte(any_byte(), 1'b0);
      budget--;
    end
    for (i = 0; i < fsz && budget > 0; i++) begin
      send_byte(any_byte(), 1'b0);
      budget--;
    end
    while (arch_pos % 4 != 0 && budget > 0) begin
      send_byte(any_byte(), 1'b0);
      budget--;
    end
  endtask

  // result side: random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (receiver_idles && $urandom_range(0, 15) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // check each accepted result
  always @(posedge clk_i) begin : watch_results
    result_t seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen            = '0;
      seen.data       = m_axis_tdata[7:0];
      seen.index      = m_axis_tdata[23:8];
      seen.entry_size = m_axis_tdata[55:24];
      seen.status     = m_axis_tdata[57:56];
      seen.region     = m_axis_tuser[2:0];
      seen.name_valid = m_axis_tuser[3];
      seen.name_last  = m_axis_tlast;
      board.check_result(seen);
    end
  end

  // stimulus
  initial begin
    int          hex_offs[2];
    int          k;
    int          e;
    int          n_entries;
    int          pick;
    int          off;
    bit          first;
    bit          cut_short;
    logic [31:0] fsz;
    logic [31:0] nsz;
    logic [7:0]  val;
    string       nm;

    board         = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    hex_offs[0]   = FSIZE_LAST;
    hex_offs[1]   = NSIZE_LAST;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero sizes, terminator-only name, near-miss trailers, then the trailer
    emit_entry(32'd0, 32'd0, "", 1'b1, -1);
    emit_entry(32'd3, 32'd1, "", 1'b0, -1);
    emit_entry(32'd2, 32'd11, "TRAILER!!?", 1'b0, -1);
    emit_entry(32'd0, 32'd11, "TRAILEr!!!", 1'b0, -1);
    emit_entry(32'd0, TRAILER_NAME_SIZE, "TRAILER!!!", 1'b0, -1);
    send_noise(6);

    // largest sizes, cut short by a restart
    emit_entry(32'hFFFF_FFFF, 32'd3, "", 1'b1, 9);
    emit_entry(32'd0, 32'hFFFF_FFFF, "", 1'b1, 6);

    // bad magic at every position, bad digits at the ends of both size fields
    for (off = 0; off < MAGIC_LEN; off++)
      emit_header(32'd0, 32'd0, 1'b1, off, (off % 2) ? 8'hFF : 8'h00, off + 3);
    for (k = 0; k < 2; k++)
      emit_header(32'd5, 32'd5, 1'b1, hex_offs[k], NOT_HEX[8*(5-k) +: 8], hex_offs[k] + 1);

    // restart in the middle of a header
    emit_header(32'd1, 32'd1, 1'b1, -1, 8'h00, 30);
    emit_entry(32'd0, TRAILER_NAME_SIZE, "TRAILER!!!", 1'b1, -1);

    // hold off until the walker has drained
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);

    // random archives
    while (bytes_sent < RANDOM_UNTIL) begin
      n_entries = $urandom_range(1, 3);
      first     = 1'b1;
      cut_short = 1'b0;
      for (e = 0; e < n_entries && !cut_short; e++) begin
        fsz  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
        nsz  = $urandom_range(0, 14);
        nm   = "";
        if ($urandom_range(0, 5) == 0) begin
          nm  = "TRAILER!!!";
          nsz = $urandom_range(9, 13);
        end
        pick = $urandom_range(0, 19);
        case (pick)
          0: begin
            off = $urandom_range(0, MAGIC_LEN - 1);
            do val = 8'($urandom_range(0, 255)); while (val == MAGIC_TEXT[8*(5-off) +: 8]);
            emit_header(fsz, nsz, first, off, val, off + 1 + $urandom_range(0, 4));
            send_noise($urandom_range(0, 4));
            cut_short = 1'b1;
          end
          1: begin
            off = ($urandom_range(0, 1) ? FSIZE_FIRST : NSIZE_FIRST) + $urandom_range(0, 7);
            do val = 8'($urandom_range(0, 255)); while (hex_digit_value(val) >= 0);
            emit_header(fsz, nsz, first, off, val, off + 1 + $urandom_range(0, 4));
            send_noise($urandom_range(0, 4));
            cut_short = 1'b1;
          end
          2: begin
            emit_entry($urandom(), ($urandom_range(0, 1) ? $urandom() : nsz), nm, first,
                       $urandom_range(0, 20));
            cut_short = 1'b1;
          end
          3: begin
            emit_header(fsz, nsz, first, -1, 8'h00, $urandom_range(1, HDR_BYTES - 1));
            cut_short = 1'b1;
          end
          default: emit_entry(fsz, nsz, nm, first, -1);
        endcase
        first = 1'b0;
      end
      if (!cut_short && $urandom_range(0, 3) != 0) begin
        emit_entry(32'd0, TRAILER_NAME_SIZE, "TRAILER!!!", 1'b0, -1);
        send_noise($urandom_range(0, 6));
      end
    end

    // closing archive at full rate on both sides
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    emit_entry(32'd0, TRAILER_NAME_SIZE, "TRAILER!!!", 1'b1, -1);
    send_noise(4);

    // drain and report
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("walked %0d bytes: header %0d, name %0d, name pad %0d, content %0d, pad %0d",
             bytes_sent, board.region_count[REG_HEADER], board.region_count[REG_NAME],
             board.region_count[REG_NAMEPAD], board.region_count[REG_CONTENT],
             board.region_count[REG_CONTENTPAD]);
    $display("stopped bytes %0d; walks ended by trailer %0d, bad magic %0d, bad digit %0d",
             board.region_count[REG_STOPPED], board.stop_count[ST_TRAILER],
             board.stop_count[ST_BAD_MAGIC], board.stop_count[ST_BAD_HEX]);
    if (board.mismatches == 0) begin
      $display("cpio_newc_archive_walker: match");
    end else begin
      $display("cpio_newc_archive_walker: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("cpio_newc_archive_walker: mismatch");
    $finish;
  end

endmodule

/* files.f */
rtl/core/cnw_pkg.sv
rtl/core/cnw_walker.sv
rtl/core/cnw_out_reg.sv
rtl/core/cpio_newc_archive_walker.sv
test/tb_cpio_newc_archive_walker.sv
